// ----- design/lad_pkg.sv -----
`default_nettype none

package lad_pkg;

    localparam int LAD_DEPTH = 8;
    localparam int VALUE_W   = 32;

    localparam logic [1:0] CMD_INS_FRONT = 2'd0;
    localparam logic [1:0] CMD_INS_REAR  = 2'd1;
    localparam logic [1:0] CMD_REM_FRONT = 2'd2;
    localparam logic [1:0] CMD_REM_REAR  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ROOM  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl;

endpackage

`default_nettype wire

// ----- design/linear_array_deque.sv -----
// Channel   Handshake            Payload
// request   i_valid / o_stall    i_command, i_value_in
// result    o_valid / i_stall    o_value_out, o_status
//
// Each request passes through capture, one access of the slot memory
// (a single port, write or registered read), and the result register.
// A new request is taken only after the previous result has been taken,
// so a stalled result holds off the request side.
// Reset empties the queue at once; slot contents are not cleared.
`default_nettype none

module linear_array_deque #(
    parameter int DEPTH = lad_pkg::LAD_DEPTH
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_valid,
    output logic                                    o_stall,
    input  wire logic [1:0]                         i_command,
    input  wire logic signed [lad_pkg::VALUE_W-1:0] i_value_in,
    output logic                                    o_valid,
    input  wire                                     i_stall,
    output logic signed [lad_pkg::VALUE_W-1:0]      o_value_out,
    output logic [1:0]                              o_status
);
    import lad_pkg::*;

    t_ctrl ctrl;

    lad_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctrl  (ctrl)
    );

    lad_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_command   (i_command),
        .i_value_in  (i_value_in),
        .o_value_out (o_value_out),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

// ----- design/lad_datapath.sv -----
`default_nettype none

module lad_datapath #(
    parameter int DEPTH = lad_pkg::LAD_DEPTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire lad_pkg::t_ctrl                i_ctrl,
    input  wire logic [1:0]                    i_command,
    input  wire logic signed [lad_pkg::VALUE_W-1:0] i_value_in,
    output logic signed [lad_pkg::VALUE_W-1:0] o_value_out,
    output logic [1:0]                         o_status
);
    import lad_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] FULL = IW'(DEPTH);
    localparam logic [IW-1:0] ONE  = IW'(1);

    // Indices are kept biased by one: zero stands for minus one.
    logic [IW-1:0]         r_front, r_rear, n_front, n_rear;
    logic [1:0]            r_cmd;
    logic [VALUE_W-1:0]    r_val;
    logic [1:0]            r_status, n_status;
    logic                  r_take, n_take;
    logic [VALUE_W-1:0]    r_rdata;
    logic [VALUE_W-1:0]    mem [DEPTH];
    logic [IW-1:0]         addr;
    logic                  we, re;

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_status = ST_DONE;
        n_take   = 1'b0;
        addr     = '0;
        we       = 1'b0;
        re       = 1'b0;
        unique case (r_cmd)
            CMD_INS_FRONT: begin
                if (r_front == '0) begin
                    n_status = ST_ROOM;
                end else begin
                    addr    = r_front - ONE;
                    we      = i_ctrl.execute;
                    n_front = r_front - ONE;
                end
            end
            CMD_INS_REAR: begin
                if (r_rear == FULL) begin
                    n_status = ST_ROOM;
                end else begin
                    addr   = r_rear;
                    we     = i_ctrl.execute;
                    n_rear = r_rear + ONE;
                end
            end
            CMD_REM_FRONT: begin
                if (r_rear == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    addr    = r_front;
                    re      = i_ctrl.execute;
                    n_take  = 1'b1;
                    n_front = r_front + ONE;
                end
            end
            CMD_REM_REAR: begin
                if (r_rear == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    addr   = r_rear - ONE;
                    re     = i_ctrl.execute;
                    n_take = 1'b1;
                    n_rear = r_rear - ONE;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
        // When the ends meet after a removal the queue is empty again.
        if (n_take && (n_front == n_rear)) begin
            n_front = '0;
            n_rear  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
        end else if (i_ctrl.execute) begin
            r_front <= n_front;
            r_rear  <= n_rear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= i_command;
            r_val <= i_value_in;
        end
        if (i_ctrl.execute) begin
            r_status <= n_status;
            r_take   <= n_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr[AW-1:0]] <= r_val;
        end
        if (re) begin
            r_rdata <= mem[addr[AW-1:0]];
        end
    end

    assign o_value_out = r_take ? signed'(r_rdata) : '0;
    assign o_status    = r_status;

endmodule

`default_nettype wire

// ----- design/lad_controller.sv -----
`default_nettype none

module lad_controller (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  wire            i_stall,
    output lad_pkg::t_ctrl o_ctrl
);
    import lad_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_ctrl.capture  = (r_state == S_IDLE) && i_valid;
    assign o_ctrl.execute  = (r_state == S_EXEC);

endmodule

`default_nettype wire

// ----- dv/deque_checker.sv -----
`timescale 1ns / 1ps

module deque_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_req_valid,
    input  wire                                i_req_stall,
    input  wire [1:0]                          i_command,
    input  wire signed [lad_pkg::VALUE_W-1:0]  i_value_in,
    input  wire                                i_rsp_valid,
    input  wire                                i_rsp_stall,
    input  wire signed [lad_pkg::VALUE_W-1:0]  i_value_out,
    input  wire [1:0]                          i_status,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import lad_pkg::*;

    localparam int IDX_W     = $clog2(LAD_DEPTH) + 1;
    localparam int PRINT_MAX = 50;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } t_deque_result;

    // Shadow copy of the queue: live elements sit above front_idx up to rear_idx.
    logic signed [VALUE_W-1:0] slot_mem [LAD_DEPTH];
    logic signed [IDX_W-1:0]   front_idx;
    logic signed [IDX_W-1:0]   rear_idx;
    t_deque_result             expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_MAX) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    function automatic t_deque_result apply_request(input logic [1:0] cmd,
                                                    input logic signed [VALUE_W-1:0] val);
        t_deque_result res;
        res.value  = '0;
        res.status = ST_DONE;
        case (cmd)
            CMD_INS_FRONT: begin
                // Only a slot freed by a front removal can take a front insert.
                if (front_idx < 0) begin
                    res.status = ST_ROOM;
                end else begin
                    slot_mem[front_idx] = val;
                    front_idx--;
                end
            end
            CMD_INS_REAR: begin
                if (rear_idx >= LAD_DEPTH - 1) begin
                    res.status = ST_ROOM;
                end else begin
                    rear_idx++;
                    slot_mem[rear_idx] = val;
                end
            end
            default: begin
                if (rear_idx < 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (cmd == CMD_REM_FRONT) begin
                        front_idx++;
                        res.value = slot_mem[front_idx];
                    end else begin
                        res.value = slot_mem[rear_idx];
                        rear_idx--;
                    end
                    if (front_idx == rear_idx) begin
                        front_idx = -1;
                        rear_idx  = -1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            front_idx = -1;
            rear_idx  = -1;
            expected_results.delete();
        end else begin
            // Results are checked before the new request is predicted, since a
            // request accepted at this edge cannot have its result out yet.
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with no transaction outstanding: value %0d status %0d",
                        i_value_out, i_status));
                end else begin
                    want = expected_results.pop_front();
                    if (i_value_out !== want.value) begin
                        report_mismatch($sformatf("value_out %0d, expected %0d",
                                                  i_value_out, want.value));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_results.push_back(apply_request(i_command, i_value_in));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import lad_pkg::*;

    localparam int RANDOM_PER_PHASE = 85;
    localparam int HOLD_ITEMS       = 40;
    localparam int DRAIN_CYCLES     = 10;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_valid    = 1'b0;
    logic [1:0]                 i_command  = CMD_INS_REAR;
    logic signed [VALUE_W-1:0]  i_value_in = '0;
    logic                       i_stall    = 1'b0;
    wire                        o_stall;
    wire                        o_valid;
    wire signed [VALUE_W-1:0]   o_value_out;
    wire [1:0]                  o_status;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 150;

    always #5 i_clk = ~i_clk;

    linear_array_deque dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_out (o_value_out),
        .o_status    (o_status)
    );

    deque_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_command    (i_command),
        .i_value_in   (i_value_in),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_value_out  (o_value_out),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus one long hold-off once requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req && hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic issue_request(input logic [1:0] cmd, input logic signed [VALUE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_value_in <= val;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Mode 0 leans toward filling, mode 1 toward draining, mode 2 churns the front.
    function automatic logic [1:0] pick_command(input int mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            0:       return (r < 60) ? CMD_INS_REAR : (r < 75) ? CMD_INS_FRONT :
                            (r < 88) ? CMD_REM_FRONT : CMD_REM_REAR;
            1:       return (r < 15) ? CMD_INS_REAR : (r < 25) ? CMD_INS_FRONT :
                            (r < 65) ? CMD_REM_FRONT : CMD_REM_REAR;
            default: return (r < 25) ? CMD_INS_REAR : (r < 55) ? CMD_INS_FRONT :
                            (r < 85) ? CMD_REM_FRONT : CMD_REM_REAR;
        endcase
    endfunction

    task automatic run_random(input int send_pct, input int stall_pct, input int count);
        int mode;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        mode = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 12 == 0) begin
                mode = $urandom_range(2);
            end
            issue_request(pick_command(mode), pick_value());
        end
    endtask

    initial begin
        #2_000_000;
        $display("linear_array_deque verification failed");
        $finish;
    end

    initial begin
        logic signed [VALUE_W-1:0] fill_vals [8];
        fill_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                      32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1, -32'sd2};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Removals and a front insert on an empty queue.
        issue_request(CMD_REM_FRONT, pick_value());
        issue_request(CMD_REM_REAR, pick_value());
        issue_request(CMD_INS_FRONT, 32'sh1234_5678);
        // Fill from the rear, then one more insert against the top.
        foreach (fill_vals[k]) begin
            issue_request(CMD_INS_REAR, fill_vals[k]);
        end
        issue_request(CMD_INS_REAR, 32'sh0bad_0bad);
        // Free two front slots and refill them; the third front insert is refused.
        issue_request(CMD_REM_FRONT, '0);
        issue_request(CMD_REM_FRONT, '0);
        issue_request(CMD_INS_FRONT, 32'sh7fff_ffff);
        issue_request(CMD_INS_FRONT, 32'sh8000_0000);
        issue_request(CMD_INS_FRONT, -32'sd1);
        issue_request(CMD_REM_REAR, '0);
        // Drain from the front until the indices meet and the queue resets.
        repeat (7) issue_request(CMD_REM_FRONT, pick_value());
        issue_request(CMD_INS_FRONT, 32'sh1);

        run_random(0, 0, RANDOM_PER_PHASE);
        run_random(80, 0, RANDOM_PER_PHASE);
        run_random(0, 80, RANDOM_PER_PHASE);
        run_random(23, 23, RANDOM_PER_PHASE);
        // Long hold-off on the result side while requests keep coming.
        hold_req = 1'b1;
        run_random(0, 0, HOLD_ITEMS);

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("linear_array_deque verification clean");
        end else begin
            $display("linear_array_deque verification failed");
        end
        $finish;
    end

endmodule
